// ----- src/wmpn_pkg.sv -----
// wmpn_pkg: types, codes and constants shared by the weighted mixer with peak normalization.
// Used by wmpn_divider and weighted_mix_peak_normalizer.
`default_nettype none

package wmpn_pkg;

   // Field and datapath widths
   localparam int SAMPLE_W    = 16;
   localparam int WEIGHT_W    = 8;
   localparam int NUM_WEIGHTS = 4;
   localparam int MASK_W      = 4;
   localparam int INDEX_W     = 12;
   localparam int CSR_IDX_W   = 3;
   localparam int ACC_W       = 26;   // 16x8 products, four of them, signed
   localparam int DIVS_W      = 16;   // divisor: total weight or peak magnitude
   localparam int CMP_W       = 17;   // holds MAX_SAMPLES up to 65536

   // Default sizing
   localparam int CHANNELS_DEF    = 4;
   localparam int MAX_SAMPLES_DEF = 4096;

   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'd32767;

   // Opcodes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic signed [SAMPLE_W-1:0] chan_sample_0;
      logic signed [SAMPLE_W-1:0] chan_sample_1;
      logic signed [SAMPLE_W-1:0] chan_sample_2;
      logic signed [SAMPLE_W-1:0] chan_sample_3;
      logic [MASK_W-1:0]          present_mask;
      logic [INDEX_W-1:0]         read_index;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] norm_sample;
      logic                       index_ok;
      logic                       overflow_seen;
      logic                       zero_weight_seen;
   } rsp_type;

   // Divider request / status
   typedef struct packed {
      logic              start;
      logic [ACC_W-1:0]  dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [ACC_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIVSET,
      ST_MIXDIV,
      ST_STORE,
      ST_GAINDIV,
      ST_MULT,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- src/wmpn_ram.sv -----
// wmpn_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module wmpn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- src/wmpn_divider.sv -----
// wmpn_divider: unsigned restoring divider, one quotient bit per cycle.
// Depends on wmpn_pkg.
`default_nettype none

module wmpn_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wmpn_pkg::div_req_type req,
   output wmpn_pkg::div_rsp_type     rsp
);

   import wmpn_pkg::*;

   localparam int CNT_W = $clog2(ACC_W + 1);

   logic [ACC_W-1:0]  dvd_ff, dvd_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DIVS_W:0]   trial;
   logic              qbit;

   // One shift-and-subtract step
   always_comb begin
      trial  = {rem_ff, dvd_ff[ACC_W-1]};
      qbit   = (trial >= {1'b0, dvs_ff});
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in = req.dividend;
         dvs_in = req.divisor;
         rem_in = '0;
         cnt_in = CNT_W'(ACC_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = qbit ? DIVS_W'(trial - {1'b0, dvs_ff}) : trial[DIVS_W-1:0];
         dvd_in = {dvd_ff[ACC_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = dvd_ff;

   // Done follows the last step of a running division
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff))
      else $error("divider done without a running division");

   // Steps counted down to zero leave the divider idle
   a_idle_at_zero: assert property (@(posedge clock) disable iff (reset)
      (run_ff && cnt_ff == CNT_W'(1) && !req.start) |=> !run_ff)
      else $error("divider kept running past its last step");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (cnt_ff != '0))
      else $error("divider running with zero step count");

endmodule

`default_nettype wire

// ----- src/weighted_mix_peak_normalizer.sv -----
// weighted_mix_peak_normalizer: weighted channel mixer with a sample store and peak gain.
// Depends on wmpn_pkg, wmpn_ram, wmpn_divider.
//
//   channel   ports                                 handshake
//   request   start, busy, req_data                 taken when start & !busy
//   response  rsp_strobe, rsp_data                  one-cycle strobe, no backpressure
//   control   csr_write_en, csr_index, csr_wdata    written on enabled edges, weight indexes only
//
// One item at a time. A load runs one channel per cycle on the shared multiply-accumulate,
// then the bit-serial divider; a load with zero total weight skips the divider.
// A read waits on the gain division. A clear is done in the idle state and never raises busy.
// The response strobe is registered and comes in the cycle after the response state;
// busy is already low then. Reset is synchronous and clears control state; the store
// itself is not cleared, and its data is used only below the stored count. The receiver
// cannot stall the response.
`default_nettype none

module weighted_mix_peak_normalizer #(
   parameter int CHANNELS    = wmpn_pkg::CHANNELS_DEF,
   parameter int MAX_SAMPLES = wmpn_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire wmpn_pkg::req_type                 req_data,
   output logic                                   rsp_strobe,
   output wmpn_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_write_en,
   input  wire logic [wmpn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [wmpn_pkg::WEIGHT_W-1:0]     csr_wdata
);

   import wmpn_pkg::*;

   localparam int MIX_CH = (CHANNELS < NUM_WEIGHTS) ? CHANNELS : NUM_WEIGHTS;
   localparam int AW     = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int PROD_W = 2 * SAMPLE_W;
   localparam int TOT_W  = WEIGHT_W + 2;

   // Control state
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SAMPLE_W-1:0]   peak_ff, peak_in;
   logic                  ovf_ff, ovf_in;
   logic                  zw_ff, zw_in;
   logic                  strobe_ff, strobe_in;
   logic [WEIGHT_W-1:0]   weight_ff [NUM_WEIGHTS];

   // Work registers
   logic signed [SAMPLE_W-1:0] smp_ff [NUM_WEIGHTS];
   logic [MASK_W-1:0]          mask_ff, mask_in;
   logic [1:0]                 ch_ff, ch_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [TOT_W-1:0]           total_ff, total_in;
   logic signed [SAMPLE_W-1:0] mixed_ff, mixed_in;
   logic                       ok_ff, ok_in;
   logic [SAMPLE_W-1:0]        gain_ff, gain_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   rsp_type                    rsp_ff, rsp_in;

   // Store and divider hookup
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [SAMPLE_W-1:0]  rd_data;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   // Combinational helpers
   logic                       accept;
   logic signed [ACC_W-1:0]    term;
   logic [ACC_W-1:0]           acc_mag;
   logic [SAMPLE_W:0]          mag;
   logic signed [SAMPLE_W:0]   gain_s;

   wmpn_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (mixed_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wmpn_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Weight registers; indexes past the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WEIGHTS; i++) begin
            weight_ff[i] <= WEIGHT_W'(1);
         end
      end else if (csr_write_en && (csr_index < CSR_IDX_W'(NUM_WEIGHTS))) begin
         weight_ff[csr_index[1:0]] <= csr_wdata;
      end
   end

   // Sequencer: next state, datapath updates and store access
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      peak_in   = peak_ff;
      ovf_in    = ovf_ff;
      zw_in     = zw_ff;
      strobe_in = 1'b0;
      mask_in   = mask_ff;
      ch_in     = ch_ff;
      acc_in    = acc_ff;
      total_in  = total_ff;
      mixed_in  = mixed_ff;
      ok_in     = ok_ff;
      gain_in   = gain_ff;
      prod_in   = prod_ff;
      rsp_in    = rsp_ff;

      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      rd_en   = 1'b0;
      rd_addr = AW'(req_data.read_index);

      div_req.start    = 1'b0;
      div_req.dividend = ACC_W'(FULL_SCALE);
      div_req.divisor  = peak_ff;

      // Operands widened to the accumulator before the multiply
      term    = mask_ff[ch_ff] ? ACC_W'(smp_ff[ch_ff]) *
                                 ACC_W'($signed({1'b0, weight_ff[ch_ff]}))
                               : '0;
      acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      mag     = mixed_ff[SAMPLE_W-1] ? (SAMPLE_W+1)'(-$signed({mixed_ff[SAMPLE_W-1], mixed_ff}))
                                     : {1'b0, mixed_ff};
      gain_s  = $signed({1'b0, gain_ff});

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.opcode)
                  OP_LOAD: begin
                     mask_in  = req_data.present_mask;
                     ch_in    = '0;
                     acc_in   = '0;
                     total_in = '0;
                     state_in = ST_MAC;
                  end
                  OP_READ: begin
                     ok_in = (CMP_W'(req_data.read_index) < CMP_W'(count_ff)) &&
                             (CMP_W'(req_data.read_index) < CMP_W'(MAX_SAMPLES));
                     rd_en         = 1'b1;
                     div_req.start = 1'b1;
                     state_in      = ST_GAINDIV;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     peak_in  = '0;
                     ovf_in   = 1'b0;
                     zw_in    = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // One channel per cycle through the shared multiplier
         ST_MAC: begin
            acc_in   = acc_ff + term;
            total_in = total_ff + TOT_W'(weight_ff[ch_ff]);
            ch_in    = ch_ff + 1'b1;
            if (ch_ff == 2'(MIX_CH - 1)) begin
               state_in = ST_DIVSET;
            end
         end

         // Zero total weight stores 0 and flags; otherwise divide magnitudes
         ST_DIVSET: begin
            if (total_ff == '0) begin
               zw_in    = 1'b1;
               mixed_in = '0;
               state_in = ST_STORE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = acc_mag;
               div_req.divisor  = DIVS_W'(total_ff);
               state_in         = ST_MIXDIV;
            end
         end

         ST_MIXDIV: begin
            if (div_rsp.done) begin
               mixed_in = acc_ff[ACC_W-1] ? SAMPLE_W'(-div_rsp.quotient)
                                          : SAMPLE_W'(div_rsp.quotient);
               state_in = ST_STORE;
            end
         end

         // Append, or drop on a full store
         ST_STORE: begin
            if (count_ff >= CNT_W'(MAX_SAMPLES)) begin
               ovf_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (mag > {1'b0, peak_ff}) begin
                  peak_in = mag[SAMPLE_W-1:0];
               end
            end
            state_in = ST_IDLE;
         end

         // Gain = max(1, 32767 / peak), 1 for a zero peak
         ST_GAINDIV: begin
            if (div_rsp.done) begin
               gain_in  = ((peak_ff == '0) || (div_rsp.quotient == '0))
                          ? SAMPLE_W'(1) : div_rsp.quotient[SAMPLE_W-1:0];
               state_in = ST_MULT;
            end
         end

         ST_MULT: begin
            prod_in  = PROD_W'($signed(rd_data)) * PROD_W'(gain_s);
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (!ok_ff) begin
               rsp_in.norm_sample = '0;
            end else if (prod_ff > PROD_W'(32767)) begin
               rsp_in.norm_sample = 16'sh7fff;
            end else if (prod_ff < -PROD_W'(32768)) begin
               rsp_in.norm_sample = 16'sh8000;
            end else begin
               rsp_in.norm_sample = prod_ff[SAMPLE_W-1:0];
            end
            rsp_in.index_ok         = ok_ff;
            rsp_in.overflow_seen    = ovf_ff;
            rsp_in.zero_weight_seen = zw_ff;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sample capture on an accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff[0] <= req_data.chan_sample_0;
         smp_ff[1] <= req_data.chan_sample_1;
         smp_ff[2] <= req_data.chan_sample_2;
         smp_ff[3] <= req_data.chan_sample_3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         peak_ff   <= '0;
         ovf_ff    <= 1'b0;
         zw_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         peak_ff   <= peak_in;
         ovf_ff    <= ovf_in;
         zw_ff     <= zw_in;
         strobe_ff <= strobe_in;
      end
      mask_ff  <= mask_in;
      ch_ff    <= ch_in;
      acc_ff   <= acc_in;
      total_ff <= total_in;
      mixed_ff <= mixed_in;
      ok_ff    <= ok_in;
      gain_ff  <= gain_in;
      prod_ff  <= prod_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // A response beat only follows the response step
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_RESP))
      else $error("response beat without a read in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("stored count beyond store depth");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < CNT_W'(MAX_SAMPLES)) && (state_ff == ST_STORE))
      else $error("store written while full or out of sequence");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.index_ok) |-> (rsp_data.norm_sample == '0))
      else $error("out-of-range read returned nonzero sample");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_MIXDIV || state_ff == ST_GAINDIV))
      else $error("divider finished outside a divide step");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// tb: self-checking bench for weighted_mix_peak_normalizer, driven beat by beat.
// Depends on wmpn_pkg and the RTL under src; it predicts the mix, the store and the peak
// gain on its own and checks every read beat.
`timescale 1ns / 100ps
`default_nettype none

module tb;
   import wmpn_pkg::*;

   localparam int          HALF_PERIOD   = 4;
   localparam int          STORE_DEPTH   = MAX_SAMPLES_DEF;
   localparam int          SETTLE_CYCLES = 40;    // longer than a load or a read takes
   localparam int          STALL_LIMIT   = 2000;
   localparam int          REQ_W         = $bits(req_type);
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam logic [2:0]  REG_WEIGHT_CH0 = 3'd0;
   localparam logic [2:0]  REG_UNMAPPED_A = 3'd5;
   localparam logic [2:0]  REG_UNMAPPED_B = 3'd6;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_strobe;
   rsp_type              rsp_data;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WEIGHT_W-1:0]  csr_wdata;

   weighted_mix_peak_normalizer dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Bench state
   req_type       frames_to_send[$];
   rsp_type       reads_due[$];
   int            beats_queued = 0;
   int            beats_taken = 0;
   logic          beat_taken = 1'b0;
   int            sender_gap = 0;
   int            mismatches = 0;
   int            quiet_cycles = 0;
   int            gen_count = 0;      // stored count as seen by the stimulus generator
   rsp_type       want;

   // Predicted block state
   logic [WEIGHT_W-1:0]        weight_q [NUM_WEIGHTS];
   logic signed [SAMPLE_W-1:0] mix_store [STORE_DEPTH];
   int                         store_count;
   int                         peak_mag;
   logic                       overflow_q;
   logic                       zero_weight_q;

   // Apply one accepted beat to the predicted state; a read queues its expected result
   function void mix_and_normalize(input req_type r);
      logic signed [SAMPLE_W-1:0] s [NUM_WEIGHTS];
      int      total;
      int      acc;
      int      mixed;
      int      mag;
      int      gain;
      int      prod;
      rsp_type e;
      s[0] = r.chan_sample_0;
      s[1] = r.chan_sample_1;
      s[2] = r.chan_sample_2;
      s[3] = r.chan_sample_3;
      case (r.opcode)
         OP_LOAD: begin
            total = 0;
            acc   = 0;
            mixed = 0;
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
               total += int'(weight_q[i]);
               if (r.present_mask[i])
                  acc += int'(s[i]) * int'(weight_q[i]);
            end
            if (total == 0)
               zero_weight_q = 1'b1;
            else
               mixed = acc / total;   // truncates toward zero
            if (store_count >= STORE_DEPTH) begin
               overflow_q = 1'b1;
            end else begin
               mix_store[store_count] = mixed[SAMPLE_W-1:0];
               store_count++;
               mag = (mixed < 0) ? -mixed : mixed;
               if (mag > peak_mag)
                  peak_mag = mag;
            end
         end
         OP_CLEAR: begin
            store_count   = 0;
            peak_mag      = 0;
            overflow_q    = 1'b0;
            zero_weight_q = 1'b0;
         end
         OP_READ: begin
            e = '0;
            if (int'(r.read_index) < store_count) begin
               gain = (peak_mag == 0) ? 1 : int'(FULL_SCALE) / peak_mag;
               if (gain < 1)
                  gain = 1;
               prod = int'(mix_store[r.read_index]) * gain;
               if (prod > 32767)
                  prod = 32767;
               else if (prod < -32768)
                  prod = -32768;
               e.norm_sample = prod[SAMPLE_W-1:0];
               e.index_ok    = 1'b1;
            end
            e.overflow_seen    = overflow_q;
            e.zero_weight_seen = zero_weight_q;
            reads_due.push_back(e);
         end
         default: ;   // unused opcode: ignored
      endcase
   endfunction

   // Monitor: check result beats first, then predict the beat taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         beat_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (reads_due.size() == 0) begin
               $error("result beat with no read pending: norm_sample %0d", rsp_data.norm_sample);
               mismatches++;
            end else begin
               want = reads_due.pop_front();
               if (rsp_data.norm_sample !== want.norm_sample) begin
                  $error("norm_sample: expected %0d, got %0d",
                         want.norm_sample, rsp_data.norm_sample);
                  mismatches++;
               end
               if (rsp_data.index_ok !== want.index_ok) begin
                  $error("index_ok: expected %0b, got %0b", want.index_ok, rsp_data.index_ok);
                  mismatches++;
               end
               if (rsp_data.overflow_seen !== want.overflow_seen) begin
                  $error("overflow_seen: expected %0b, got %0b",
                         want.overflow_seen, rsp_data.overflow_seen);
                  mismatches++;
               end
               if (rsp_data.zero_weight_seen !== want.zero_weight_seen) begin
                  $error("zero_weight_seen: expected %0b, got %0b",
                         want.zero_weight_seen, rsp_data.zero_weight_seen);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            mix_and_normalize(req_data);
            beats_taken <= beats_taken + 1;
         end
         beat_taken <= start && !busy;
         if (csr_write_en && csr_index < NUM_WEIGHTS)
            weight_q[csr_index] = csr_wdata;
      end
   end

   // Driver: hold a beat until taken, then present the next one or idle
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (frames_to_send.size() != 0 && $urandom_range(0, 99) >= sender_gap) begin
            req_data <= frames_to_send.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Watchdog: nothing taken, returned or written for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[weighted_mix_peak_normalizer] ERROR");
         $finish;
      end
   end

   // Stimulus helpers
   task automatic queue_beat(input req_type r);
      frames_to_send.push_back(r);
      beats_queued++;
      if (r.opcode == OP_LOAD && gen_count < STORE_DEPTH)
         gen_count++;
      else if (r.opcode == OP_CLEAR)
         gen_count = 0;
   endtask

   function automatic req_type noise_beat(input logic [1:0] op);
      req_type r;
      r = REQ_W'({$urandom, $urandom, $urandom});
      r.opcode = op;
      return r;
   endfunction

   task automatic queue_load(input int s0, input int s1, input int s2, input int s3,
                             input logic [MASK_W-1:0] mask);
      req_type r;
      r = noise_beat(OP_LOAD);
      r.chan_sample_0 = s0[SAMPLE_W-1:0];
      r.chan_sample_1 = s1[SAMPLE_W-1:0];
      r.chan_sample_2 = s2[SAMPLE_W-1:0];
      r.chan_sample_3 = s3[SAMPLE_W-1:0];
      r.present_mask  = mask;
      queue_beat(r);
   endtask

   task automatic queue_read(input int idx);
      req_type r;
      r = noise_beat(OP_READ);
      r.read_index = idx[INDEX_W-1:0];
      queue_beat(r);
   endtask

   function automatic int scaled_sample(input int shift);
      logic signed [SAMPLE_W-1:0] v;
      v = SAMPLE_W'($urandom);
      return int'(v >>> shift);
   endfunction

   // Wait until every beat is taken and every read has returned, then let the block settle
   task automatic drain();
      while (beats_taken != beats_queued || reads_due.size() != 0 || busy)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_weights(input int w0, input int w1, input int w2, input int w3);
      int w [NUM_WEIGHTS];
      w = '{w0, w1, w2, w3};
      for (int i = 0; i < NUM_WEIGHTS; i++)
         csr_write(REG_WEIGHT_CH0 + CSR_IDX_W'(i), w[i][WEIGHT_W-1:0]);
   endtask

   function automatic int sparse_weight();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
   endfunction

   // Mostly loads and in-range reads, with a few clears and unused opcodes
   task automatic random_run(input int beats, input int gap);
      int shift;
      int pick;
      sender_gap = gap;
      shift = $urandom_range(0, 15);
      for (int n = 0; n < beats; n++) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0)
            shift = $urandom_range(0, 15);
         if (pick < 45) begin
            queue_load(scaled_sample(shift), scaled_sample(shift), scaled_sample(shift),
                       scaled_sample(shift), MASK_W'($urandom_range(0, 15)));
         end else if (pick < 90) begin
            if (gen_count > 0 && $urandom_range(0, 9) < 8)
               queue_read($urandom_range(0, gen_count - 1));
            else
               queue_read($urandom_range(0, 4095));
         end else if (pick < 96) begin
            queue_beat(noise_beat(OP_CLEAR));
            shift = $urandom_range(0, 15);
         end else begin
            queue_beat(noise_beat(OP_UNUSED));
         end
      end
      drain();
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      csr_write_en  = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      store_count   = 0;
      peak_mag      = 0;
      overflow_q    = 1'b0;
      zero_weight_q = 1'b0;
      for (int i = 0; i < NUM_WEIGHTS; i++)
         weight_q[i] = 8'd1;
      for (int i = 0; i < STORE_DEPTH; i++)
         mix_store[i] = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed, reset weights (all 1)
      sender_gap = 0;
      queue_read(0);                                     // empty store
      queue_read(4095);
      queue_load(32767, 32767, 32767, 32767, 4'hF);      // positive full scale
      queue_load(-32768, -32768, -32768, -32768, 4'hF);  // peak of -32768: gain 1
      queue_read(0);
      queue_read(1);
      queue_read(2);                                     // one past the count
      queue_beat(noise_beat(OP_CLEAR));
      queue_read(0);                                     // cleared store
      queue_load(1234, -999, 77, 5, 4'h0);               // no channel present
      queue_read(0);                                     // peak zero: gain 1
      queue_load(100, 0, 0, 0, 4'h1);
      queue_load(-7, 0, 0, 0, 4'h1);                     // truncation toward zero
      queue_read(1);
      queue_read(2);
      queue_beat(noise_beat(OP_UNUSED));                 // ignored
      queue_load(1000, -2000, 3000, -4000, 4'hA);
      queue_read(3);
      queue_beat(noise_beat(OP_CLEAR));
      drain();

      // Directed, all weights zero; unmapped indexes must be ignored
      set_weights(0, 0, 0, 0);
      csr_write(REG_UNMAPPED_A, 8'hFF);
      csr_write(REG_UNMAPPED_B, 8'h55);
      queue_load(4000, -3000, 2000, -1000, 4'hF);        // zero total weight
      queue_read(0);
      queue_beat(noise_beat(OP_CLEAR));
      queue_read(0);
      drain();

      // Random runs over several weight settings and sender idle rates
      set_weights(255, 255, 255, 255);
      random_run(200, 9);
      set_weights($urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      random_run(200, 9);
      set_weights(0, 0, 0, 255);
      random_run(200, 47);
      set_weights(sparse_weight(), sparse_weight(), sparse_weight(), sparse_weight());
      random_run(200, 47);
      set_weights($urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      random_run(200, 0);
      set_weights(255, 1, 128, 0);
      random_run(200, 0);

      if (mismatches == 0 && reads_due.size() == 0)
         $display("[weighted_mix_peak_normalizer] OK");
      else
         $display("[weighted_mix_peak_normalizer] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
